// ===== rtl/mexp_pkg.sv =====
// ============================================================================
// mexp_pkg
// Shared types and constants for the modular exponentiation core.
// ============================================================================
package mexp_pkg;

    // Default operand width in bits.
    localparam int MEXP_WIDTH = 32;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_BIT,
        ST_MUL_ACC,
        ST_SQ_START,
        ST_SQUARE,
        ST_DONE
    } state_t;

    // Operand pair fed to the modular multiplier.
    typedef enum logic [1:0] {
        OP_BASE,   // 1 * base, which reduces the base
        OP_ACC,    // accumulator * square
        OP_SQ      // square * square
    } op_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    mul_start;
        op_sel_t op_sel;
        logic    wr_sq;
        logic    wr_acc;
        logic    shift_exp;
        logic    emit;
    } mexp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic exp_hi_zero;
        logic mul_done;
        logic out_free;
    } mexp_status_t;

endpackage

// ===== rtl/mexp_mulmod.sv =====
// ============================================================================
// mexp_mulmod
// Shift-add modular multiplier: r = x * y mod m, one bit of y per cycle.
// ============================================================================
module mexp_mulmod #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] x_in,     // must not exceed m
    input  logic [WIDTH-1:0] y_in,     // any value
    input  logic [WIDTH-1:0] m_in,     // nonzero, held during the operation
    output logic             done,
    output logic [WIDTH-1:0] result
);
    import mexp_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] y_reg, y_next;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] mod1;
    logic [WIDTH+1:0] mod2;

    // One step: r = 2r + bit*x, then bring it back below m. Since r < m and
    // x <= m, the sum stays below 3m, so at most 2m has to be taken off.
    always_comb begin
        mod1 = {2'b00, m_in};
        mod2 = {1'b0, m_in, 1'b0};
        sum  = {1'b0, r_reg, 1'b0} + (y_reg[WIDTH-1] ? {2'b00, x_reg} : '0);
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH);
            r_next    = '0;
            x_next    = x_in;
            y_next    = y_in;
        end else if (busy_reg) begin
            if (sum >= mod2) begin
                r_next = WIDTH'(sum - mod2);
            end else if (sum >= mod1) begin
                r_next = WIDTH'(sum - mod1);
            end else begin
                r_next = WIDTH'(sum);
            end
            y_next   = {y_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and partial-result registers.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        r_reg   <= r_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

// ===== rtl/mexp_dp.sv =====
// ============================================================================
// mexp_dp
// Datapath: operand, accumulator and square registers, the modular
// multiplier and the output register.
// ============================================================================
module mexp_dp #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mexp_pkg::mexp_cmd_t    cmd,
    output mexp_pkg::mexp_status_t status,
    input  logic [WIDTH-1:0]       base_in,
    input  logic [WIDTH-1:0]       exponent_in,
    input  logic [WIDTH-1:0]       modulus_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [WIDTH-1:0]       power_result
);
    import mexp_pkg::*;

    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] exp_reg, exp_next;
    logic [WIDTH-1:0] mod_reg, mod_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] sq_reg, sq_next;
    logic [WIDTH-1:0] res_reg, res_next;
    logic             out_valid_reg, out_valid_next;

    logic [WIDTH-1:0] mul_x;
    logic [WIDTH-1:0] mul_y;
    logic [WIDTH-1:0] mul_r;
    logic             mul_done;

    // Operand selection for the multiplier.
    always_comb begin
        unique case (cmd.op_sel)
            OP_BASE: begin
                mul_x = WIDTH'(1);
                mul_y = base_reg;
            end
            OP_ACC: begin
                mul_x = acc_reg;
                mul_y = sq_reg;
            end
            OP_SQ: begin
                mul_x = sq_reg;
                mul_y = sq_reg;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .x_in    (mul_x),
        .y_in    (mul_y),
        .m_in    (mod_reg),
        .done    (mul_done),
        .result  (mul_r)
    );

    // Register updates on controller commands.
    always_comb begin
        base_next      = base_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            base_next = base_in;
            exp_next  = exponent_in;
            mod_next  = modulus_in;
            // The accumulator starts at 1 mod m, which is 0 for m of 0 or 1.
            acc_next  = (modulus_in[WIDTH-1:1] == '0) ? '0 : WIDTH'(1);
        end
        if (cmd.wr_sq) begin
            sq_next = mul_r;
        end
        if (cmd.wr_acc) begin
            acc_next = mul_r;
        end
        if (cmd.shift_exp) begin
            exp_next = {1'b0, exp_reg[WIDTH-1:1]};
        end
        // The output register empties when taken and refills on emit.
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            res_next       = acc_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        mod_reg  <= mod_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
    end

    // Status back to the controller.
    always_comb begin
        status.mod_zero    = (mod_reg == '0);
        status.exp_zero    = (exp_reg == '0);
        status.exp_lsb     = exp_reg[0];
        status.exp_hi_zero = (exp_reg[WIDTH-1:1] == '0);
        status.mul_done    = mul_done;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign power_result = res_reg;

endmodule

// ===== rtl/mexp_ctrl.sv =====
// ============================================================================
// mexp_ctrl
// Controller: sequences the base reduction and the square-and-multiply
// steps over the exponent bits, least significant bit first.
// ============================================================================
module mexp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  mexp_pkg::mexp_status_t status,
    output mexp_pkg::mexp_cmd_t    cmd
);
    import mexp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.mod_zero ? ST_DONE : ST_REDUCE;
            end
            ST_REDUCE: begin
                if (status.mul_done) begin
                    state_next = ST_BIT;
                end
            end
            ST_BIT: begin
                if (status.exp_zero) begin
                    state_next = ST_DONE;
                end else if (status.exp_lsb) begin
                    state_next = ST_MUL_ACC;
                end else begin
                    state_next = ST_SQUARE;
                end
            end
            ST_MUL_ACC: begin
                if (status.mul_done) begin
                    state_next = ST_SQ_START;
                end
            end
            ST_SQ_START: begin
                // No higher exponent bits: the last square is never used.
                state_next = status.exp_hi_zero ? ST_DONE : ST_SQUARE;
            end
            ST_SQUARE: begin
                if (status.mul_done) begin
                    state_next = ST_BIT;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.mul_start = 1'b0;
        cmd.op_sel    = OP_BASE;
        cmd.wr_sq     = 1'b0;
        cmd.wr_acc    = 1'b0;
        cmd.shift_exp = 1'b0;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CHECK: begin
                cmd.mul_start = !status.mod_zero;
                cmd.op_sel    = OP_BASE;
            end
            ST_REDUCE: begin
                cmd.wr_sq = status.mul_done;
            end
            ST_BIT: begin
                cmd.mul_start = !status.exp_zero;
                cmd.op_sel    = status.exp_lsb ? OP_ACC : OP_SQ;
            end
            ST_MUL_ACC: begin
                cmd.wr_acc = status.mul_done;
            end
            ST_SQ_START: begin
                cmd.mul_start = !status.exp_hi_zero;
                cmd.op_sel    = OP_SQ;
            end
            ST_SQUARE: begin
                cmd.op_sel    = OP_SQ;
                cmd.wr_sq     = status.mul_done;
                cmd.shift_exp = status.mul_done;
            end
            ST_DONE: begin
                cmd.emit = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/modular_exponentiation_core.sv =====
// ============================================================================
// modular_exponentiation_core
// Computes base ** exponent mod modulus by right-to-left binary
// square-and-multiply on a shared shift-add modular multiplier.
// ============================================================================
//
//  Channel | Direction | Fields (lowest bits first)
//  --------+-----------+------------------------------------------
//  s_      | in        | base, exponent, modulus (tdata)
//  m_      | out       | power_result (tdata)
//
//  Each item takes one multiply to reduce the base, one per set exponent bit
//  and one square per exponent bit below the highest set one; a zero exponent
//  needs only the reduction and a zero modulus no multiply at all. Each
//  multiply takes one multiplier bit per cycle, plus a start and a finish step.
//  One item is worked on at a time; a finished result waits in the output
//  register while the next item is accepted, and a result still untaken
//  when the next one finishes holds the core until it is taken. Reset is
//  synchronous, active low, and leaves the core idle with no result pending.
//
module modular_exponentiation_core #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // base, exponent, modulus, zero padding
    input  logic [((3*WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // power_result, zero padding
    output logic [((WIDTH+7)/8)*8-1:0]          m_tdata
);
    import mexp_pkg::*;

    localparam int M_TDATA_W = ((WIDTH + 7) / 8) * 8;

    mexp_cmd_t        cmd;
    mexp_status_t     status;
    logic [WIDTH-1:0] power_result;

    mexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .base_in      (s_tdata[WIDTH-1:0]),
        .exponent_in  (s_tdata[2*WIDTH-1:WIDTH]),
        .modulus_in   (s_tdata[3*WIDTH-1:2*WIDTH]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .power_result (power_result)
    );

    assign m_tdata = M_TDATA_W'(power_result);

endmodule

// ===== rtl/mexp_checker.sv =====
// ============================================================================
// mexp_assertions
// Port-level checks for the modular exponentiation core.
// ============================================================================
module mexp_assertions #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [((3*WIDTH+7)/8)*8-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [((WIDTH+7)/8)*8-1:0]   m_tdata
);
    import mexp_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Once an item is taken the core is busy with it.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // No result can appear in the cycle right after an item is accepted.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared without computation");

    // Reset leaves the core ready and with no pending result.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("core not idle after reset");

endmodule

bind modular_exponentiation_core mexp_assertions #(
    .WIDTH (WIDTH)
) u_mexp_assertions (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/mexp_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// mexp_checker
// Watches both streams of the modular exponentiation core, computes the
// expected power for every accepted request and compares it with each
// accepted result, oldest expectation first.
// ============================================================================
module mexp_checker #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // base, exponent, modulus, zero padding
    input  logic [((3*WIDTH+7)/8)*8-1:0]        s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // power_result, zero padding
    input  logic [((WIDTH+7)/8)*8-1:0]          m_tdata,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  checked_count
);

    localparam int OUT_W       = ((WIDTH + 7) / 8) * 8;
    localparam int REPORT_MAX  = 10;

    // One outstanding request with the power it must produce.
    typedef struct packed {
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] exponent;
        logic [WIDTH-1:0] modulus;
        logic [OUT_W-1:0] power;
    } power_req_t;

    power_req_t expected_power_q[$];
    int         fails  = 0;
    int         checks = 0;

    // Right-to-left square-and-multiply; every product is reduced.
    function automatic logic [WIDTH-1:0] predict_power(
        input logic [WIDTH-1:0] base,
        input logic [WIDTH-1:0] exponent,
        input logic [WIDTH-1:0] modulus
    );
        logic [2*WIDTH-1:0] acc;
        logic [2*WIDTH-1:0] sq;
        logic [2*WIDTH-1:0] m;
        int                 i;
        // A zero modulus has no defined arithmetic; the core answers zero.
        if (modulus == '0) begin
            return '0;
        end
        m   = modulus;
        acc = (2*WIDTH)'(1) % m;
        sq  = base % m;
        for (i = 0; i < WIDTH; i++) begin
            if (exponent[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[WIDTH-1:0];
    endfunction

    // Results are retired before new requests are queued in the same cycle.
    always @(posedge aclk) begin
        power_req_t want;
        power_req_t req;
        if (!aresetn) begin
            expected_power_q.delete();
            fails  = 0;
            checks = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_power_q.size() == 0) begin
                    if (fails < REPORT_MAX) begin
                        $display("%0t: unexpected result item power=%h", $realtime, m_tdata);
                    end
                    fails++;
                end else begin
                    want = expected_power_q.pop_front();
                    if (m_tdata !== want.power) begin
                        if (fails < REPORT_MAX) begin
                            $display("%0t: power mismatch base=%h exp=%h mod=%h",
                                     $realtime, want.base, want.exponent, want.modulus);
                            $display("    expected %h, got %h", want.power, m_tdata);
                        end
                        fails++;
                    end
                    checks++;
                end
            end
            if (s_tvalid && s_tready) begin
                req.base     = s_tdata[WIDTH-1:0];
                req.exponent = s_tdata[2*WIDTH-1:WIDTH];
                req.modulus  = s_tdata[3*WIDTH-1:2*WIDTH];
                req.power    = OUT_W'(predict_power(req.base, req.exponent, req.modulus));
                expected_power_q.push_back(req);
            end
        end
        fail_count    <= fails;
        checked_count <= checks;
        pending_count <= expected_power_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb
// Drives directed and random exponentiation requests into the core under
// four traffic phases and reports the checker's verdict.
// ============================================================================
module tb;

    localparam int WIDTH            = mexp_pkg::MEXP_WIDTH;
    localparam int IN_W             = ((3 * WIDTH + 7) / 8) * 8;
    localparam int OUT_W            = ((WIDTH + 7) / 8) * 8;
    localparam int RANDOM_PER_PHASE = 65;
    localparam int DRAIN_CYCLES     = 2200;
    localparam int QUIET_LIMIT      = 20000;

    typedef enum int {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE
    } traffic_phase_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    int                fail_count;
    int                pending_count;
    int                checked_count;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int                items_sent     = 0;
    int                quiet_cycles   = 0;

    modular_exponentiation_core #(
        .WIDTH (WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mexp_checker #(
        .WIDTH (WIDTH)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // 12 ns clock.
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Result side back-pressure for the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Ends the run when no item moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", pending_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Presents one request, with random idle cycles ahead of it.
    task automatic send_power_req(
        input logic [WIDTH-1:0] base,
        input logic [WIDTH-1:0] exponent,
        input logic [WIDTH-1:0] modulus
    );
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({modulus, exponent, base});
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    initial begin
        traffic_phase_t   ph;
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] e;
        logic [WIDTH-1:0] m;
        logic [63:0]      emask;
        int               msb;
        int               k;
        int unsigned      pick;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: modulus one, exponent zero, base zero, zero modulus, extremes.
        send_power_req(32'h0, 32'h0, 32'h1);
        send_power_req(32'h5, 32'h0, 32'h1);
        send_power_req('1, '1, 32'h1);
        send_power_req(32'h7, 32'h0, 32'd13);
        send_power_req(32'h0, 32'h0, '1);
        send_power_req(32'h0, 32'h5, 32'h7);
        send_power_req(32'h0, '1, '1);
        send_power_req(32'h3, 32'h4, 32'h0);
        send_power_req('1, '1, 32'h0);
        send_power_req('1, '1, '1);
        send_power_req('1, '1, 32'hFFFF_FFFE);
        send_power_req(32'h4, 32'd13, 32'd497);
        send_power_req(32'h2, 32'd31, '1);
        send_power_req(32'hDEAD_BEEF, '1, 32'hFFFF_FFFB);
        send_power_req(32'h3, 32'h1, 32'h2);
        send_power_req(32'h1234_5678, 32'h8000_0000, 32'h000F_4243);
        send_power_req(32'h3, 32'd100, 32'h8000_0000);
        send_power_req('1, 32'h2, 32'h8000_0001);
        send_power_req(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCD);
        send_power_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333);

        // Random requests; most exponents get a random highest set bit, a few are zero, one or all ones.
        ph = ph.first();
        repeat (4) begin
            case (ph)
                PH_STEADY: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                PH_SEND_IDLE: begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                end
                PH_RECV_STALL: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                end
                default: begin
                    send_idle_pct  = 12;
                    recv_stall_pct = 12;
                end
            endcase
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    m = $urandom();
                    if (m == '0) begin
                        m = 32'h1;
                    end
                end else if (pick < 60) begin
                    m = $urandom_range(1000, 1);
                end else if (pick < 75) begin
                    m = 32'h1 << $urandom_range(WIDTH - 1);
                end else if (pick < 85) begin
                    m = $urandom() | 32'h8000_0001;
                end else if (pick < 93) begin
                    m = ~WIDTH'($urandom_range(15));
                end else if (pick < 97) begin
                    m = 32'h1;
                end else if (pick < 99) begin
                    m = '1;
                end else begin
                    m = '0;
                end

                pick = $urandom_range(99);
                if (pick < 60) begin
                    b = $urandom();
                end else if (pick < 70) begin
                    b = (m != '0) ? WIDTH'($urandom() % m) : WIDTH'($urandom());
                end else if (pick < 80) begin
                    b = '0;
                end else if (pick < 90) begin
                    b = 32'h1;
                end else if (pick < 95) begin
                    b = '1;
                end else begin
                    b = m - WIDTH'(1);
                end

                pick = $urandom_range(99);
                if (pick < 85) begin
                    msb   = $urandom_range(WIDTH - 1);
                    emask = (64'd1 << (msb + 1)) - 64'd1;
                    e     = WIDTH'($urandom() & emask) | (WIDTH'(1) << msb);
                end else if (pick < 90) begin
                    e = '0;
                end else if (pick < 95) begin
                    e = 32'h1;
                end else begin
                    e = '1;
                end

                send_power_req(b, e, m);
            end
            ph = ph.next();
        end

        // Drain: let the last request register, then wait for every result.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d power requests across steady, sender-idle, receiver-stall",
                 items_sent);
        $display("and mixed traffic; %0d results compared, %0d failures.",
                 checked_count, fail_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== modular_exponentiation_core.f =====
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/mexp_dp.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation_core.sv
rtl/mexp_checker.sv
tb/mexp_checker.sv
tb/tb.sv
